// File: rtl/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared widths, palette sizing and hold-and-modify operation codes.
// ----------------------------------------------------------------------------
package hpd_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned RGB_W     = 3 * CHAN_W;
  localparam int unsigned IN_DATA_W = 40;  // code, index, red, green, blue
  localparam int unsigned IN_USER_W = 2;   // kind, line_start
  localparam int unsigned OUT_DATA_W = RGB_W;
  localparam int unsigned OUT_USER_W = 1;  // transparent

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAL_WRITE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'b00,
    OP_BLUE  = 2'b01,
    OP_RED   = 2'b10,
    OP_GREEN = 2'b11
  } ham_op_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

// File: rtl/ham_pixel_decoder.sv
// ----------------------------------------------------------------------------
// ham_pixel_decoder
// Hold-and-modify pixel decoder (6-bit / 8-bit) with a loadable palette.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake           | payload
//  s_axis    | in  | tvalid/tready       | tdata: code, index, r, g, b; tuser: kind, line_start
//  m_axis    | out | tvalid/tready/tlast | tdata: r, g, b; tuser: transparent
//  ham_mode  | in  | ham_mode_we_i       | ham_mode_i
//
// Each pixel holds the output register for its two doubled results; the next
// pixel waits in the pixel stage until the second is taken. A pixel goes from
// accept through the palette read register to the output register. Async
// active-low reset clears control and held colour; the palette holds no reset
// value. Output stalls back up through the pixel stage to s_axis_tready_o.
module ham_pixel_decoder
  import hpd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ham_mode_we_i,
  input  logic                  ham_mode_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [7:0] pixel_code, [15:8] palette_index, [23:16] palette_red,
  // [31:24] palette_green, [39:32] palette_blue
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] kind, [1] line_start
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] transparent
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  logic              mode_q;

  // input fields
  logic              in_kind;
  logic              in_line_start;
  logic [7:0]        in_code;
  logic [7:0]        in_idx;
  rgb_t              in_rgb;
  logic              in_acc;

  // palette
  logic [RGB_W-1:0]  pal_mem [PALETTE_ENTRIES];
  logic [RGB_W-1:0]  pal_rd_q;

  // pixel stage
  logic              s1_v_q;
  logic [7:0]        s1_code_q;
  logic              s1_ls_q;
  logic              s1_oob_q;
  logic              s1_adv;

  // held colour and output register
  rgb_t              held_q, held_d, pal_rgb, base;
  logic [CHAN_W-1:0] mod_val;
  ham_op_e           op;
  logic              out_v_q, out_last_q, out_tr_q;
  rgb_t              out_rgb_q;
  logic              out_acc;

  assign in_kind       = s_axis_tuser_i[0];
  assign in_line_start = s_axis_tuser_i[1];
  assign in_code       = s_axis_tdata_i[7:0];
  assign in_idx        = s_axis_tdata_i[15:8];
  assign in_rgb.red    = s_axis_tdata_i[23:16];
  assign in_rgb.green  = s_axis_tdata_i[31:24];
  assign in_rgb.blue   = s_axis_tdata_i[39:32];

  assign out_acc = out_v_q && m_axis_tready_i;
  assign s1_adv  = s1_v_q && (!out_v_q || (out_acc && out_last_q));
  assign s_axis_tready_o = !s1_v_q || s1_adv;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (ham_mode_we_i) begin
      mode_q <= ham_mode_i;
    end
  end

  // Writes and reads both happen at accept, in item order, so a load right
  // after a write to the same entry sees the new colour.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_kind == KIND_PAL_WRITE) begin
        if ({1'b0, in_idx} < 9'(PALETTE_ENTRIES)) begin
          pal_mem[in_idx[PAL_AW-1:0]] <= in_rgb;
        end
      end else begin
        pal_rd_q <= pal_mem[in_code[PAL_AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= (in_kind == KIND_PIXEL);
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_kind == KIND_PIXEL) begin
      s1_code_q <= in_code;
      s1_ls_q   <= in_line_start;
      s1_oob_q  <= !({1'b0, in_code} < 9'(PALETTE_ENTRIES));
    end
  end

  // decode
  always_comb begin
    pal_rgb = s1_oob_q ? '0 : rgb_t'(pal_rd_q);
    base    = s1_ls_q ? '0 : held_q;
    if (mode_q) begin
      op      = ham_op_e'(s1_code_q[7:6]);
      mod_val = {s1_code_q[5:0], 2'b00};
    end else begin
      op      = ham_op_e'(s1_code_q[5:4]);
      mod_val = {s1_code_q[3:0], s1_code_q[3:0]};
    end
    held_d = base;
    if (s1_code_q != 8'd0) begin
      unique case (op)
        OP_LOAD:  held_d = pal_rgb;
        OP_BLUE:  held_d.blue = mod_val;
        OP_RED:   held_d.red = mod_val;
        OP_GREEN: held_d.green = mod_val;
        default:  held_d = base;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        held_q     <= held_d;
        out_v_q    <= 1'b1;
        out_last_q <= 1'b0;
      end else if (out_acc) begin
        if (out_last_q) begin
          out_v_q <= 1'b0;
        end else begin
          out_last_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_tr_q  <= (s1_code_q == 8'd0);
      out_rgb_q <= (s1_code_q == 8'd0) ? '0 : held_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_tr_q;
  assign m_axis_tdata_o  = {out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red};

endmodule

// File: rtl/hpd_checker.sv
// ----------------------------------------------------------------------------
// hpd_checker
// Port-level checks on the doubled result stream of ham_pixel_decoder.
// ----------------------------------------------------------------------------
module hpd_checker
  import hpd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o,
  input logic                  m_axis_tlast_o
);

  // second result of a pixel follows right after the first
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o)
      |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("second result of pixel missing");

  a_pair_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o)
      |=> ($stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("doubled results differ");

  a_transp_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("transparent result carries color");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i)
      |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind ham_pixel_decoder hpd_checker u_hpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
